FILE: hw/rtl/mavt_pkg.sv
`timescale 1ns / 1ps

package mavt_pkg;

  localparam int ANGLE_W = 12;
  localparam int DT_W    = 16;
  localparam int SPOS_W  = 16;
  localparam int POS_W   = 32;
  localparam int TURN_W  = 32;

  localparam int unsigned COUNTS_PER_TURN = 4096;
  // wrap-around threshold: 5*|d| > 4*COUNTS_PER_TURN
  localparam int unsigned WRAP_LIM        = 4 * COUNTS_PER_TURN;
  localparam logic [POS_W-1:0] CPT_W      = POS_W'(COUNTS_PER_TURN);

  // count change per update stays within one turn of a 12-bit angle
  localparam int NUM_W    = ANGLE_W + 2;
  localparam int MAG_W    = NUM_W - 1;
  localparam int CNT_W    = $clog2(MAG_W);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic OP_INIT   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic                    upd;
    logic [SPOS_W-1:0]       single_pos;
    logic [POS_W-1:0]        multi_pos;
    logic signed [NUM_W-1:0] num;
    logic [DT_W-1:0]         dt;
  } mavt_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mavt_qstat_t;

endpackage

FILE: hw/rtl/mavt_front.sv
`timescale 1ns / 1ps

module mavt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mavt_pkg::ANGLE_W-1:0]   zero_offset,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [mavt_pkg::ANGLE_W-1:0]   angle,
  input  logic [mavt_pkg::DT_W-1:0]      dt,
  input  mavt_pkg::mavt_qstat_t          qstat,
  output logic                           push,
  output mavt_pkg::mavt_item_t           item
);
  import mavt_pkg::*;

  logic [ANGLE_W-1:0]      last_angle_r, last_angle_nxt;
  logic [TURN_W-1:0]       turn_r, turn_nxt;
  logic signed [ANGLE_W:0] d;
  logic [ANGLE_W-1:0]      ad;
  logic [ANGLE_W+3:0]      ad5;
  logic                    wrap;
  logic                    turn_up;
  logic                    turn_dn;
  logic signed [NUM_W-1:0] num;
  logic [TURN_W-1:0]       turn_upd;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    d       = $signed({1'b0, angle}) - $signed({1'b0, last_angle_r});
    ad      = d[ANGLE_W] ? ANGLE_W'(-d) : ANGLE_W'(d);
    ad5     = (ANGLE_W+4)'(ad) * (ANGLE_W+4)'(5);
    wrap    = 32'(ad5) > WRAP_LIM;
    turn_up = wrap && d[ANGLE_W];
    turn_dn = wrap && !d[ANGLE_W];
    if (turn_up) begin
      turn_upd = turn_r + TURN_W'(1);
      num      = NUM_W'(d) + NUM_W'(COUNTS_PER_TURN);
    end else if (turn_dn) begin
      turn_upd = turn_r - TURN_W'(1);
      num      = NUM_W'(d) - NUM_W'(COUNTS_PER_TURN);
    end else begin
      turn_upd = turn_r;
      num      = NUM_W'(d);
    end

    item.upd        = (op == OP_UPDATE);
    item.single_pos = SPOS_W'(angle) - SPOS_W'(zero_offset);
    item.multi_pos  = turn_upd * CPT_W + POS_W'(angle) - POS_W'(zero_offset);
    item.num        = num;
    item.dt         = dt;

    last_angle_nxt = push ? angle : last_angle_r;
    turn_nxt       = (push && op == OP_UPDATE) ? turn_upd : turn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_angle_r <= '0;
      turn_r       <= '0;
    end else begin
      last_angle_r <= last_angle_nxt;
      turn_r       <= turn_nxt;
    end
  end

endmodule

FILE: hw/rtl/mavt_queue.sv
`timescale 1ns / 1ps

module mavt_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mavt_pkg::mavt_item_t  push_item,
  input  logic                  pop,
  output mavt_pkg::mavt_item_t  pop_item,
  output mavt_pkg::mavt_qstat_t qstat
);
  import mavt_pkg::*;

  mavt_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt;
  logic [QPTR_W-1:0]   rd_r, rd_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_item    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/mavt_back.sv
`timescale 1ns / 1ps

module mavt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mavt_pkg::mavt_qstat_t         qstat,
  input  mavt_pkg::mavt_item_t          item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mavt_pkg::SPOS_W-1:0]   single_pos,
  output logic [mavt_pkg::POS_W-1:0]    multi_pos,
  output logic [mavt_pkg::POS_W-1:0]    speed,
  output logic                          zero_flag
);
  import mavt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t         state_r, state_nxt;
  logic                upd_r;
  logic                zero_r;
  logic                neg_r;
  logic [SPOS_W-1:0]   single_r;
  logic [POS_W-1:0]    multi_r;
  logic [DT_W-1:0]     dt_r;
  logic [MAG_W-1:0]    quo_r;
  logic [DT_W-1:0]     rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DT_W:0]       trial;
  logic                ge;
  logic [MAG_W-1:0]    mag;
  logic [POS_W-1:0]    quot_s;
  logic                out_free;
  logic                load_out;

  logic                out_valid_r;
  logic [SPOS_W-1:0]   held_single_r;
  logic [POS_W-1:0]    held_multi_r;
  logic [POS_W-1:0]    held_speed_r;
  logic                flag_r;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == ST_IDLE) && !qstat.empty;
  assign load_out = (state_r == ST_DONE) && out_free;

  always_comb begin
    trial  = {rem_r, quo_r[MAG_W-1]};
    ge     = trial >= {1'b0, dt_r};
    mag    = item.num[NUM_W-1] ? MAG_W'(-item.num) : MAG_W'(item.num);
    quot_s = neg_r ? -POS_W'(quo_r) : POS_W'(quo_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = (item.upd && item.dt != '0) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // item latch and restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      upd_r    <= item.upd;
      zero_r   <= (item.dt == '0);
      neg_r    <= item.num[NUM_W-1];
      single_r <= item.single_pos;
      multi_r  <= item.multi_pos;
      dt_r     <= item.dt;
      quo_r    <= mag;
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= ge ? DT_W'(trial - {1'b0, dt_r}) : DT_W'(trial);
      quo_r <= {quo_r[MAG_W-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      held_single_r <= '0;
      held_multi_r  <= '0;
      held_speed_r  <= '0;
      flag_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        flag_r      <= upd_r && zero_r;
        // an init beat repeats the held results
        if (upd_r) begin
          held_single_r <= single_r;
          held_multi_r  <= multi_r;
          held_speed_r  <= zero_r ? '0 : quot_s;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign single_pos = held_single_r;
  assign multi_pos  = held_multi_r;
  assign speed      = held_speed_r;
  assign zero_flag  = flag_r;

endmodule

FILE: hw/rtl/multiturn_angle_velocity_tracker.sv
`timescale 1ns / 1ps
// Multi-turn position and velocity tracker for a 12-bit single-turn encoder.
// Input stream: in_tuser selects init (load stored angle) or update; in_tdata
// carries the raw angle and the milliseconds since the previous update.
// Each input beat yields exactly one output beat on the out_ stream with the
// single-turn position, multi-turn position and speed in counts per ms;
// out_tuser flags an update with zero elapsed time (speed forced to 0).
// cfg_wen/cfg_wdata load the zero offset; write it only while idle.
// Path: an update reaches out_tvalid through the queue entry, the back-end
// load, 13 steps of the restoring divider (one quotient bit per cycle) and
// the output register load. An init beat, or an update with zero elapsed
// time, skips the divider. One item is in the back end at a time; it pops no
// new item until its result is loaded. A two-entry queue sits between the
// front end (turn tracking) and the back end (division and output register),
// so inputs keep flowing while a result waits. When the receiver stalls, the
// output beat holds, the back end waits, and in_tready drops once the queue
// fills.
// Reset clears the stored angle, turn count, held results and offset.
module multiturn_angle_velocity_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [11:0] cfg_wdata,   // zero_offset
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // angle_sample[11:0], elapsed_ms[27:12], zero pad
  input  logic [0:0]  in_tuser,    // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,   // single_turn_position[15:0],
                                   // multi_turn_position[47:16], speed[79:48]
  output logic [0:0]  out_tuser    // zero_time_flag
);
  import mavt_pkg::*;

  logic [ANGLE_W-1:0] zero_offset_r;
  logic               push;
  logic               pop;
  mavt_item_t         push_item;
  mavt_item_t         pop_item;
  mavt_qstat_t        qstat;
  logic [SPOS_W-1:0]  single_pos;
  logic [POS_W-1:0]   multi_pos;
  logic [POS_W-1:0]   speed;
  logic               zero_flag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= '0;
    end else if (cfg_wen) begin
      zero_offset_r <= cfg_wdata;
    end
  end

  mavt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .zero_offset (zero_offset_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser[0]),
    .angle       (in_tdata[ANGLE_W-1:0]),
    .dt          (in_tdata[ANGLE_W+DT_W-1:ANGLE_W]),
    .qstat       (qstat),
    .push        (push),
    .item        (push_item)
  );

  mavt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  mavt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .item       (pop_item),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .single_pos (single_pos),
    .multi_pos  (multi_pos),
    .speed      (speed),
    .zero_flag  (zero_flag)
  );

  assign out_tdata = {speed, multi_pos, single_pos};
  assign out_tuser = zero_flag;

endmodule

FILE: hw/rtl/mavt_checker.sv
`timescale 1ns / 1ps

module mavt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat offered right after reset");

  // zero elapsed time forces the speed to zero
  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[79:48] == 32'd0)
    else $error("zero-time beat carries nonzero speed");

endmodule

bind multiturn_angle_velocity_tracker mavt_checker u_mavt_checker (.*);
